// File: hdl/text_console_character_engine_assert.svh
// ---------------------------------------------------------------------------
// Text console assertion macros
// Shared concurrent assertion forms for the text console character engine.
// Expects signals named clock and reset in the using scope.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define TCCE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console assertion failed");

// Next-cycle implication, off while reset is high
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console assertion failed");

`endif

// File: hdl/tcce_pkg.sv
// ---------------------------------------------------------------------------
// Text console package
// Word types, character and opcode codes, and the sequencer control store.
// ---------------------------------------------------------------------------
package tcce_pkg;

   // Opcodes of the request word
   localparam logic [1:0] OPC_PUT   = 2'd0;
   localparam logic [1:0] OPC_READ  = 2'd1;
   localparam logic [1:0] OPC_CLEAR = 2'd2;

   // Control characters
   localparam logic [7:0] CHAR_NUL = 8'd0;
   localparam logic [7:0] CHAR_BS  = 8'd8;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_LF  = 8'd10;

   localparam int         TAB_STEP         = 4;
   localparam logic [3:0] BLANK_FILL_COLOR = 4'hF;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [3:0] color;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [3:0]  cell_color;
      logic        scrolled;
   } rsp_word_type;

   // One screen cell: color in the upper nibble, character below
   typedef struct packed {
      logic [3:0] color;
      logic [7:0] char_code;
   } cell_type;

   // Control store addresses
   localparam logic [4:0] UC_CLEAR        = 5'd0;
   localparam logic [4:0] UC_END          = 5'd1;
   localparam logic [4:0] UC_READ         = 5'd2;
   localparam logic [4:0] UC_READ_LATCH   = 5'd3;
   localparam logic [4:0] UC_TAB          = 5'd4;
   localparam logic [4:0] UC_PUT          = 5'd5;
   localparam logic [4:0] UC_CHECK        = 5'd6;
   localparam logic [4:0] UC_NEWLINE      = 5'd7;
   localparam logic [4:0] UC_COPY_PRIME   = 5'd8;
   localparam logic [4:0] UC_COPY         = 5'd9;
   localparam logic [4:0] UC_FILL         = 5'd10;
   localparam logic [4:0] UC_BLANK        = 5'd11;
   localparam logic [4:0] UC_BS_START     = 5'd12;
   localparam logic [4:0] UC_BS_COL0      = 5'd13;
   localparam logic [4:0] UC_BS_UP        = 5'd14;
   localparam logic [4:0] UC_BS_SCAN_RD   = 5'd15;
   localparam logic [4:0] UC_BS_SCAN_TEST = 5'd16;
   localparam logic [4:0] UC_BS_SCAN_DEC  = 5'd17;
   localparam logic [4:0] UC_BS_DEC       = 5'd18;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CHAR,
      WR_BLANK,
      WR_ZERO,
      WR_COPY,
      WR_FILL
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_REQ,
      RD_CURSOR,
      RD_SHIFT
   } rd_sel_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_TAB,
      CUR_NEWLINE,
      CUR_UP,
      CUR_DEC
   } cur_op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_COL_IN_RANGE,
      COND_NO_SCROLL,
      COND_NOT_LAST_ALL,
      COND_NOT_LAST_COPY,
      COND_ORIGIN,
      COND_COL_NONZERO,
      COND_COL_ZERO,
      COND_CHAR_NONZERO
   } cond_type;

   typedef struct packed {
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      cur_op_type cur_op;
      logic       addr_inc;
      logic       latch_cell;
      logic       done;
      cond_type   cond;
      logic [4:0] target;
   } ucode_type;

   // Control store: jump to target when cond holds, else fall through
   function automatic ucode_type uc_rom(input logic [4:0] step);
      ucode_type uw;
      uw = '{wr_sel: WR_NONE, rd_sel: RD_NONE, cur_op: CUR_HOLD, addr_inc: 1'b0,
             latch_cell: 1'b0, done: 1'b0, cond: COND_ALWAYS, target: UC_END};
      case (step)
         UC_CLEAR: begin
            uw.wr_sel   = WR_ZERO;
            uw.addr_inc = 1'b1;
            uw.cond     = COND_NOT_LAST_ALL;
            uw.target   = UC_CLEAR;
         end
         UC_END: begin
            uw.done = 1'b1;
            uw.cond = COND_NEVER;
         end
         UC_READ: begin
            uw.rd_sel = RD_REQ;
            uw.cond   = COND_NEVER;
         end
         UC_READ_LATCH: begin
            uw.latch_cell = 1'b1;
         end
         UC_TAB: begin
            uw.cur_op = CUR_TAB;
            uw.target = UC_CHECK;
         end
         UC_PUT: begin
            uw.wr_sel = WR_CHAR;
            uw.cur_op = CUR_INC;
            uw.cond   = COND_NEVER;
         end
         UC_CHECK: begin
            uw.cond   = COND_COL_IN_RANGE;
            uw.target = UC_BLANK;
         end
         UC_NEWLINE: begin
            uw.cur_op = CUR_NEWLINE;
            uw.cond   = COND_NO_SCROLL;
            uw.target = UC_BLANK;
         end
         UC_COPY_PRIME: begin
            uw.rd_sel = RD_SHIFT;
            uw.cond   = COND_NEVER;
         end
         UC_COPY: begin
            uw.wr_sel   = WR_COPY;
            uw.rd_sel   = RD_SHIFT;
            uw.addr_inc = 1'b1;
            uw.cond     = COND_NOT_LAST_COPY;
            uw.target   = UC_COPY;
         end
         UC_FILL: begin
            uw.wr_sel   = WR_FILL;
            uw.addr_inc = 1'b1;
            uw.cond     = COND_NOT_LAST_ALL;
            uw.target   = UC_FILL;
         end
         UC_BLANK: begin
            uw.wr_sel = WR_BLANK;
         end
         UC_BS_START: begin
            uw.cond = COND_ORIGIN;
         end
         UC_BS_COL0: begin
            uw.cond   = COND_COL_NONZERO;
            uw.target = UC_BS_DEC;
         end
         UC_BS_UP: begin
            uw.cur_op = CUR_UP;
            uw.cond   = COND_NEVER;
         end
         UC_BS_SCAN_RD: begin
            uw.rd_sel = RD_CURSOR;
            uw.cond   = COND_COL_ZERO;
            uw.target = UC_BLANK;
         end
         UC_BS_SCAN_TEST: begin
            uw.cond   = COND_CHAR_NONZERO;
            uw.target = UC_BLANK;
         end
         UC_BS_SCAN_DEC: begin
            uw.cur_op = CUR_DEC;
            uw.target = UC_BS_SCAN_RD;
         end
         UC_BS_DEC: begin
            uw.cur_op = CUR_DEC;
            uw.target = UC_BLANK;
         end
         default: begin
            uw.cond = COND_ALWAYS;
         end
      endcase
      return uw;
   endfunction

   // Entry point of the program for one request word
   function automatic logic [4:0] uc_entry(input req_word_type w);
      logic [4:0] step;
      step = UC_END;
      case (w.opcode)
         OPC_PUT: begin
            case (w.char_code)
               CHAR_NUL: step = UC_END;
               CHAR_LF:  step = UC_NEWLINE;
               CHAR_TAB: step = UC_TAB;
               CHAR_BS:  step = UC_BS_START;
               default:  step = UC_PUT;
            endcase
         end
         OPC_READ:  step = UC_READ;
         OPC_CLEAR: step = UC_CLEAR;
         default:   step = UC_END;
      endcase
      return step;
   endfunction

endpackage

// File: hdl/text_console_character_engine.sv
// ---------------------------------------------------------------------------
// Text console character engine
// Character screen with a cursor: put character, read cell, clear screen,
// run by a microcoded sequencer over a single-port-write cell memory.
// ---------------------------------------------------------------------------
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+----------------------------
//  request  | req_valid req_stall req_word  | opcode, character, color, cell
//  result   | rsp_valid rsp_stall rsp_word  | cursor, read cell, scroll flag
//
// One request at a time. A scroll adds to a newline, put or tab one priming
// read, then one cell copied or filled per cycle through the memory port.
// Backspace from column 0 scans left over empty cells. After reset a
// clearing pass runs before the first request is taken. A stalled result
// holds in the output register; the next request still runs and waits at
// its last step for the register to free.
//
`include "text_console_character_engine_assert.svh"

module text_console_character_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcce_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcce_pkg::rsp_word_type rsp_word
);
   import tcce_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int AW1   = AW + 1;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS + TAB_STEP);

   localparam logic [CW-1:0]  COL_LIMIT      = CW'(COLUMNS);
   localparam logic [CW-1:0]  COL_LAST       = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]  ROW_LAST       = RW'(ROWS - 1);
   localparam logic [AW-1:0]  ADDR_LAST      = AW'(CELLS - 1);
   localparam logic [AW-1:0]  ADDR_COPY_LAST = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW1-1:0] CELLS_W        = AW1'(CELLS);
   localparam logic [AW1-1:0] COLUMNS_W      = AW1'(COLUMNS);

   // Sequencer state
   logic         busy_ff, busy_in;
   logic         silent_ff, silent_in;
   logic [4:0]   pc_ff, pc_in;
   logic [AW-1:0] addr_ff, addr_in;

   // Cursor and flags
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          scroll_ff, scroll_in;

   // Payload registers
   req_word_type req_ff, req_in;
   cell_type     cell_ff, cell_in;
   cell_type     rd_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // Cell memory
   cell_type mem [CELLS];

   ucode_type     uw;
   logic          jump;
   logic          finish;
   logic          req_take;
   logic          wr_en;
   logic [AW-1:0] waddr;
   cell_type      wdata;
   logic          rd_en;
   logic [AW-1:0] raddr;
   logic [AW1-1:0] cur_addr_wide;
   logic [AW1-1:0] req_addr_wide;
   logic [AW1-1:0] shift_wide;
   logic          req_in_range;

   assign uw        = uc_rom(pc_ff);
   assign req_stall = busy_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Form cell addresses
   assign cur_addr_wide = AW1'(row_ff) * COLUMNS_W + AW1'(col_ff);
   assign req_addr_wide = AW1'(req_ff.read_row) * COLUMNS_W + AW1'(req_ff.read_col);
   assign req_in_range  = (req_ff.read_row < ROWS) && (req_ff.read_col < COLUMNS);
   assign shift_wide    = AW1'(addr_in) + COLUMNS_W;

   // Evaluate the jump condition
   always_comb begin
      case (uw.cond)
         COND_NEVER:         jump = 1'b0;
         COND_ALWAYS:        jump = 1'b1;
         COND_COL_IN_RANGE:  jump = col_ff < COL_LIMIT;
         COND_NO_SCROLL:     jump = row_ff != ROW_LAST;
         COND_NOT_LAST_ALL:  jump = addr_ff != ADDR_LAST;
         COND_NOT_LAST_COPY: jump = addr_ff != ADDR_COPY_LAST;
         COND_ORIGIN:        jump = (row_ff == '0) && (col_ff == '0);
         COND_COL_NONZERO:   jump = col_ff != '0;
         COND_COL_ZERO:      jump = col_ff == '0;
         COND_CHAR_NONZERO:  jump = rd_ff.char_code != '0;
         default:            jump = 1'b0;
      endcase
   end

   // Finish when the result register is free or the pass is silent
   assign finish = busy_ff && uw.done && (silent_ff || !rsp_valid_ff || !rsp_stall);

   // Advance the step counter
   always_comb begin
      busy_in   = busy_ff;
      silent_in = silent_ff;
      pc_in     = pc_ff;
      addr_in   = addr_ff;
      if (req_take) begin
         busy_in   = 1'b1;
         silent_in = 1'b0;
         pc_in     = uc_entry(req_word);
         addr_in   = '0;
      end else if (busy_ff) begin
         if (uw.done) begin
            if (finish) begin
               busy_in = 1'b0;
            end
         end else if (jump) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 5'd1;
         end
         if (uw.addr_inc) begin
            addr_in = addr_ff + AW'(1);
         end
      end
   end

   // Move the cursor
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      scroll_in = scroll_ff;
      if (req_take) begin
         scroll_in = 1'b0;
      end else if (busy_ff) begin
         case (uw.cur_op)
            CUR_HOLD: ;
            CUR_INC:  col_in = col_ff + CW'(1);
            CUR_TAB:  col_in = col_ff + CW'(TAB_STEP);
            CUR_NEWLINE: begin
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  scroll_in = 1'b1;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
            CUR_UP: begin
               row_in = row_ff - RW'(1);
               col_in = COL_LAST;
            end
            CUR_DEC:  col_in = col_ff - CW'(1);
            default: ;
         endcase
      end
   end

   // Select the memory write
   always_comb begin
      wr_en = busy_ff;
      waddr = addr_ff;
      wdata = '0;
      case (uw.wr_sel)
         WR_NONE: wr_en = 1'b0;
         WR_CHAR: begin
            waddr = cur_addr_wide[AW-1:0];
            wdata = '{color: req_ff.color, char_code: req_ff.char_code};
         end
         WR_BLANK: begin
            waddr = cur_addr_wide[AW-1:0];
            wdata = '{color: req_ff.color, char_code: CHAR_NUL};
         end
         WR_ZERO: wdata = '0;
         WR_COPY: wdata = rd_ff;
         WR_FILL: wdata = '{color: BLANK_FILL_COLOR, char_code: CHAR_NUL};
         default: wr_en = 1'b0;
      endcase
   end

   // Select the memory read
   always_comb begin
      rd_en = 1'b0;
      raddr = cur_addr_wide[AW-1:0];
      case (uw.rd_sel)
         RD_NONE: rd_en = 1'b0;
         RD_REQ: begin
            rd_en = busy_ff && req_in_range;
            raddr = req_addr_wide[AW-1:0];
         end
         RD_CURSOR: rd_en = busy_ff;
         RD_SHIFT: begin
            rd_en = busy_ff && (shift_wide < CELLS_W);
            raddr = shift_wide[AW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   // Capture the request and the read cell
   always_comb begin
      req_in  = req_take ? req_word : req_ff;
      cell_in = cell_ff;
      if (req_take) begin
         cell_in = '0;
      end else if (busy_ff && uw.latch_cell) begin
         cell_in = req_in_range ? rd_ff : '0;
      end
   end

   // Load the result word
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish && !silent_ff) begin
         rsp_in.cursor_row = 5'(row_ff);
         rsp_in.cursor_col = 7'(col_ff);
         rsp_in.cursor_pos = 11'(cur_addr_wide);
         rsp_in.cell_char  = cell_ff.char_code;
         rsp_in.cell_color = cell_ff.color;
         rsp_in.scrolled   = scroll_ff;
         rsp_valid_in      = 1'b1;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         silent_ff    <= 1'b1;
         pc_ff        <= UC_CLEAR;
         addr_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         silent_ff    <= silent_in;
         pc_ff        <= pc_in;
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cell_ff <= cell_in;
      rsp_ff  <= rsp_in;
   end

   // Write the cell memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   // Read the cell memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[raddr];
      end
   end

   `TCCE_ASSERT_IMPLY(a_idle_cursor, !busy_ff, (col_ff < COL_LIMIT) && (row_ff <= ROW_LAST))
   `TCCE_ASSERT_IMPLY(a_scroll_row, scroll_ff, row_ff == ROW_LAST)
   `TCCE_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, busy_ff && !silent_ff)
   `TCCE_ASSERT_IMPLY(a_rsp_scroll, rsp_valid_ff && rsp_ff.scrolled, rsp_ff.cursor_row == 5'(ROW_LAST))

endmodule

// File: tb/tb_text_console_character_engine.sv
// ---------------------------------------------------------------------------
// Text console character engine testbench
// Sends put, read, clear and unused-opcode words through the request
// channel with random bursts and gaps, and stalls the result channel on
// its own pattern. A screen model in the bench predicts every result
// word, which is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_character_engine;
   import tcce_pkg::*;

   localparam int          SCREEN_COLS    = 80;
   localparam int          SCREEN_ROWS    = 25;
   localparam int          SCREEN_CELLS   = SCREEN_COLS * SCREEN_ROWS;
   localparam logic [1:0]  OPC_UNUSED     = 2'd3;
   localparam int          RANDOM_WORDS   = 250;
   localparam int          HOLDOFF_AFTER  = 60;
   localparam int          HOLDOFF_CYCLES = 400;
   localparam int          SETTLE_CYCLES  = 2200;
   localparam int unsigned CYCLE_LIMIT    = 4_000_000;

   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_type;

   typedef struct {
      req_word_type word;
      bit           wait_idle;
   } console_cmd_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Screen model
   cell_type screen_cells [SCREEN_CELLS];
   int       console_row;
   int       console_col;

   console_cmd_type console_cmds[$];
   rsp_word_type    cursor_reports_due[$];

   int          words_queued   = 0;
   int          words_accepted = 0;
   int          error_count    = 0;
   int unsigned cycle_count    = 0;
   bit          idle_next      = 1'b0;

   // Driver and receiver state
   bit          word_taken   = 1'b0;
   int          burst_left   = 0;
   int          gap_left     = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 1'b0;
   rx_mode_type rx_mode      = RX_FREE;
   int          rx_mode_left = 0;

   text_console_character_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Move the model cursor to the next line, scrolling at the bottom
   function automatic bit feed_line();
      int c;
      console_col = 0;
      if (console_row + 1 >= SCREEN_ROWS) begin
         console_row = SCREEN_ROWS - 1;
         for (c = 0; c < SCREEN_CELLS - SCREEN_COLS; c++)
            screen_cells[c] = screen_cells[c + SCREEN_COLS];
         for (c = SCREEN_CELLS - SCREEN_COLS; c < SCREEN_CELLS; c++)
            screen_cells[c] = '{color: BLANK_FILL_COLOR, char_code: CHAR_NUL};
         return 1'b1;
      end
      console_row++;
      return 1'b0;
   endfunction

   // Apply one request word to the screen model and build its result word
   function automatic rsp_word_type step_console(input req_word_type w);
      rsp_word_type r;
      bit           do_blank;
      int           idx;
      r        = '0;
      do_blank = 1'b1;
      if (w.opcode == OPC_PUT && w.char_code != CHAR_NUL) begin
         case (w.char_code)
            CHAR_LF: begin
               r.scrolled = feed_line();
            end
            CHAR_TAB: begin
               console_col += TAB_STEP;
               if (console_col >= SCREEN_COLS)
                  r.scrolled = feed_line();
            end
            CHAR_BS: begin
               if (console_row == 0 && console_col == 0) begin
                  do_blank = 1'b0;
               end else if (console_col == 0) begin
                  // back up a row, then skip empty cells from the right
                  console_row--;
                  console_col = SCREEN_COLS - 1;
                  while (console_col != 0 &&
                         screen_cells[console_row * SCREEN_COLS + console_col].char_code
                            == CHAR_NUL)
                     console_col--;
               end else begin
                  console_col--;
               end
            end
            default: begin
               screen_cells[console_row * SCREEN_COLS + console_col] =
                  '{color: w.color, char_code: w.char_code};
               console_col++;
               if (console_col >= SCREEN_COLS)
                  r.scrolled = feed_line();
            end
         endcase
         if (do_blank)
            screen_cells[console_row * SCREEN_COLS + console_col] =
               '{color: w.color, char_code: CHAR_NUL};
      end else if (w.opcode == OPC_READ) begin
         if (w.read_row < SCREEN_ROWS && w.read_col < SCREEN_COLS) begin
            idx          = w.read_row * SCREEN_COLS + w.read_col;
            r.cell_char  = screen_cells[idx].char_code;
            r.cell_color = screen_cells[idx].color;
         end
      end else if (w.opcode == OPC_CLEAR) begin
         foreach (screen_cells[k])
            screen_cells[k] = '0;
      end
      r.cursor_row = 5'(console_row);
      r.cursor_col = 7'(console_col);
      r.cursor_pos = 11'(console_row * SCREEN_COLS + console_col);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [10:0] want,
                              input logic [10:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Stimulus helpers
   task automatic queue_cmd(input logic [1:0] opc, input logic [7:0] ch,
                            input logic [4:0] rr, input logic [6:0] rc);
      console_cmd_type cmd;
      cmd.word      = '{opcode: opc, char_code: ch, color: 4'($urandom_range(0, 15)),
                        read_row: rr, read_col: rc};
      cmd.wait_idle = idle_next;
      idle_next     = 1'b0;
      console_cmds.push_back(cmd);
      words_queued++;
   endtask

   task automatic queue_put(input logic [7:0] ch);
      queue_cmd(OPC_PUT, ch, 5'($urandom), 7'($urandom));
   endtask

   task automatic queue_read(input logic [4:0] rr, input logic [6:0] rc);
      queue_cmd(OPC_READ, 8'($urandom), rr, rc);
   endtask

   function automatic logic [7:0] random_glyph();
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 255));
      while (c == CHAR_BS || c == CHAR_TAB || c == CHAR_LF);
      return c;
   endfunction

   // Stimulus and end of run
   initial begin
      int kind;
      int n;
      int i;
      int row;
      int mark;
      int random_count;
      bit counts;

      foreach (screen_cells[k])
         screen_cells[k] = '0;
      console_row = 0;
      console_col = 0;

      // Directed: origin backspace, NUL, extremes, every opcode
      idle_next = 1'b1;
      queue_put(CHAR_BS);
      queue_put(CHAR_NUL);
      queue_read(5'd0, 7'd0);
      queue_put(8'h41);
      queue_put(8'hFF);
      queue_put(8'h01);
      queue_put(8'h7F);
      queue_read(5'd0, 7'd0);
      queue_read(5'd0, 7'd1);
      queue_read(5'd0, 7'd3);
      queue_put(CHAR_TAB);
      queue_put(CHAR_BS);
      queue_put(CHAR_LF);
      queue_put(CHAR_BS);
      queue_read(5'd0, 7'd4);
      queue_read(5'd25, 7'd0);
      queue_read(5'd31, 7'd127);
      queue_read(5'd0, 7'd80);
      queue_read(5'd24, 7'd79);
      queue_cmd(OPC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
      queue_cmd(OPC_CLEAR, 8'h00, 5'd0, 7'd0);
      queue_read(5'd0, 7'd0);
      queue_put(CHAR_LF);
      queue_put(CHAR_LF);
      queue_put(CHAR_BS);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Random: mostly lines of text with edits, some reads and noise
      random_count = 0;
      while (random_count < RANDOM_WORDS) begin
         while (console_cmds.size() > 4)
            @(negedge clock);
         mark   = words_queued;
         counts = 1'b1;
         if (random_count == 0 || $urandom_range(0, 19) == 0)
            idle_next = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 38) begin
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
               queue_put(random_glyph());
            if ($urandom_range(0, 99) < 85)
               queue_put(CHAR_LF);
         end else if (kind < 48) begin
            n = $urandom_range(2, 6);
            for (i = 0; i < n; i++)
               queue_put(CHAR_LF);
         end else if (kind < 56) begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
               queue_put(CHAR_TAB);
         end else if (kind < 62) begin
            // run the cursor to the right edge and wrap it
            n = $urandom_range(17, 20);
            for (i = 0; i < n; i++)
               queue_put(CHAR_TAB);
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
               queue_put(random_glyph());
         end else if (kind < 74) begin
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
               queue_put(CHAR_LF);
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
               queue_put(CHAR_BS);
         end else if (kind < 88) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) < 7) begin
                  row = console_row - int'($urandom_range(0, 2));
                  if (row < 0)
                     row = 0;
                  queue_read(5'(row), $urandom_range(0, 1) ? 7'($urandom_range(0, 12))
                                                           : 7'($urandom_range(0, 79)));
               end else begin
                  queue_read(5'($urandom), 7'($urandom));
               end
            end
         end else if (kind < 90) begin
            queue_cmd(OPC_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            queue_read(5'($urandom_range(0, 24)), 7'($urandom_range(0, 79)));
         end else if (kind < 96) begin
            // words that leave the screen and cursor as they are
            counts = 1'b0;
            if ($urandom_range(0, 1))
               queue_put(CHAR_NUL);
            else
               queue_cmd(OPC_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
         end else begin
            queue_cmd(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
         end
         if (counts)
            random_count += words_queued - mark;
      end

      // Drain, then settle
      while (words_accepted < words_queued || cursor_reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Request driver: bursts with gaps, optional wait for an idle block
   always @(negedge clock) begin : driver
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer      = req_valid && !word_taken;
         word_taken = 1'b0;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (console_cmds.size() != 0 &&
                         !(console_cmds[0].wait_idle && cursor_reports_due.size() != 0)) begin
               req_word <= console_cmds[0].word;
               void'(console_cmds.pop_front());
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  if ($urandom_range(0, 3) == 0)
                     gap_left = 0;
                  else if ($urandom_range(0, 7) == 0)
                     gap_left = $urandom_range(10, 40);
                  else
                     gap_left = $urandom_range(1, 6);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // Result stall pattern, with one long hold-off to back up the block
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && words_accepted >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_FREE:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:  rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: predict on request accept, check on result accept
   always @(posedge clock) begin : monitor
      rsp_word_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            cursor_reports_due.push_back(step_console(req_word));
            word_taken = 1'b1;
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (cursor_reports_due.size() == 0) begin
               $display("%0t: result word with none due, expected nothing, actual %h",
                        $time, rsp_word);
               error_count++;
            end else begin
               due = cursor_reports_due.pop_front();
               check_field("cursor_row", 11'(due.cursor_row), 11'(rsp_word.cursor_row));
               check_field("cursor_col", 11'(due.cursor_col), 11'(rsp_word.cursor_col));
               check_field("cursor_pos", due.cursor_pos, rsp_word.cursor_pos);
               check_field("cell_char", 11'(due.cell_char), 11'(rsp_word.cell_char));
               check_field("cell_color", 11'(due.cell_color), 11'(rsp_word.cell_color));
               check_field("scrolled", 11'(due.scrolled), 11'(rsp_word.scrolled));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
